[hdl/ultrasonic_range_controller_macros.svh]
// assertion macros shared by the range controller modules
// expects clk and rst_n in the scope of each use
`ifndef ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define URC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urc check failed");

// next-cycle implication, checked out of reset
`define URC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urc check failed");

`endif

[hdl/urc_pkg.sv]
// types and constants of the ultrasonic range controller
// no dependencies
package urc_pkg;

    localparam int unsigned RANGE_W = 11;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned TPC_W = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [RANGE_W-1:0] RANGE_MAX = 11'd1129;
    localparam logic [TICK_W-1:0] TICK_SAT = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM = 2'd2;

    // register reset values: 1 ms trigger, 50 ms timeout, 58 us per cm
    localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd50000;
    localparam logic [TPC_W-1:0] TICKS_PER_CM_RST = 8'd58;

    typedef struct packed {
        logic [TICK_W-1:0] trigger_ticks;
        logic [TICK_W-1:0] timeout_ticks;
        logic [TPC_W-1:0]  ticks_per_cm;
    } cfg_t;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } sample_t;

    typedef struct packed {
        logic               trigger_level;
        logic               done_res;
        logic               timed_out;
        logic [RANGE_W-1:0] range_cm;
    } result_t;

endpackage

[hdl/urc_if.sv]
// valid/ready channel interfaces of the range controller
// depends on urc_pkg for the field widths
interface urc_sample_if;
    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink (input valid, input start_request, input echo_level, output ready);
endinterface

interface urc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        done_res;
    logic                        timed_out;
    logic [urc_pkg::RANGE_W-1:0] range_cm;

    modport source (output valid, output trigger_level, output done_res,
                    output timed_out, output range_cm, input ready);
    modport sink (input valid, input trigger_level, input done_res,
                  input timed_out, input range_cm, output ready);
endinterface

[hdl/ultrasonic_range_controller.sv]
// ultrasonic range controller: an accepted input word passes through the input register,
// the sequencer logic and the result register to its result word
// throughput one word per cycle while result.ready holds; each input word gives
// exactly one result word; the result register frees as it is taken, so the
// input side keeps flowing; reset (rst_n low, async) clears the sequencer to idle,
// range 0, empty registers, and loads the register defaults 1000 / 50000 / 58
module ultrasonic_range_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [urc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    urc_sample_if.sink                    sample,
    urc_result_if.source                  result
);

    // configuration registers
    urc_pkg::cfg_t    cfg_reg;

    // input register: one captured tick word
    logic             in_valid_reg;
    urc_pkg::sample_t in_word_reg;

    // result register
    logic             out_valid_reg;
    urc_pkg::result_t out_word_reg;

    logic             advance;
    urc_pkg::result_t step_res;

    // a held word moves on when the result register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    // register writes; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= urc_pkg::TRIGGER_TICKS_RST;
            cfg_reg.timeout_ticks <= urc_pkg::TIMEOUT_TICKS_RST;
            cfg_reg.ticks_per_cm <= urc_pkg::TICKS_PER_CM_RST;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                urc_pkg::CFG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_wdata;
                urc_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata;
                urc_pkg::CFG_TICKS_PER_CM:
                    cfg_reg.ticks_per_cm <= cfg_wdata[urc_pkg::TPC_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_word_reg.start_request <= sample.start_request;
            in_word_reg.echo_level <= sample.echo_level;
        end
    end

    // sequencer steps once per word moved into the result register
    urc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cfg     (cfg_reg),
        .smp     (in_word_reg),
        .res     (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.trigger_level = out_word_reg.trigger_level;
    assign result.done_res = out_word_reg.done_res;
    assign result.timed_out = out_word_reg.timed_out;
    assign result.range_cm = out_word_reg.range_cm;

`include "ultrasonic_range_controller_macros.svh"

    // error flag only ever rides on a done word
    `URC_ASSERT_NOW(a_err_with_done, out_valid_reg && out_word_reg.timed_out,
                    out_word_reg.done_res)
    // a captured word that cannot move on stays put
    `URC_ASSERT_NEXT(a_in_word_kept, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_word_reg))

endmodule

[hdl/urc_seq.sv]
// measurement sequencer: phase, tick timer, centimetre counter, held range
// depends on urc_pkg and ultrasonic_range_controller_macros.svh
module urc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  urc_pkg::cfg_t    cfg,
    input  urc_pkg::sample_t smp,
    output urc_pkg::result_t res
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [urc_pkg::TICK_W-1:0]          phase_ticks_reg, phase_ticks_next;
    logic [urc_pkg::TPC_W-1:0]           cm_prescale_reg, cm_prescale_next;
    logic [urc_pkg::RANGE_W-1:0]         cm_count_reg, cm_count_next;
    logic                                echo_before_reg;
    logic [urc_pkg::RANGE_W-1:0]         range_held_reg, range_held_next;

    logic                                rise, fall;
    logic [urc_pkg::TICK_W-1:0]          ticks_inc;
    logic                                timeout_hit;
    logic [urc_pkg::TPC_W-1:0]           pre_base, pre_inc, pre_step;
    logic [urc_pkg::RANGE_W-1:0]         cnt_base, cnt_step;
    logic                                done, err;

    assign rise = smp.echo_level & ~echo_before_reg;
    assign fall = ~smp.echo_level & echo_before_reg;

    // saturating tick timer shared by trigger and timeout checks
    assign ticks_inc = (phase_ticks_reg != urc_pkg::TICK_SAT) ?
                       phase_ticks_reg + 1'b1 : phase_ticks_reg;
    assign timeout_hit = (ticks_inc >= cfg.timeout_ticks);

    // one high echo tick; the rise tick starts from a cleared count
    always_comb
    begin
        pre_base = (phase_reg == PH_WAIT) ? '0 : cm_prescale_reg;
        cnt_base = (phase_reg == PH_WAIT) ? '0 : cm_count_reg;
        pre_inc = pre_base + 1'b1;
        if (pre_inc >= cfg.ticks_per_cm)
        begin
            pre_step = '0;
            cnt_step = (cnt_base < urc_pkg::RANGE_MAX) ? cnt_base + 1'b1 : cnt_base;
        end
        else
        begin
            pre_step = pre_inc;
            cnt_step = cnt_base;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        cm_prescale_next = cm_prescale_reg;
        cm_count_next = cm_count_reg;
        range_held_next = range_held_reg;
        done = 1'b0;
        err = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (smp.start_request)
                begin
                    phase_next = PH_TRIG;
                    phase_ticks_next = '0;
                end
            end
            PH_TRIG:
            begin
                if (ticks_inc >= cfg.trigger_ticks)
                begin
                    phase_next = PH_WAIT;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            PH_WAIT:
            begin
                if (rise)
                begin
                    phase_next = PH_MEAS;
                    phase_ticks_next = '0;
                    cm_prescale_next = pre_step;
                    cm_count_next = cnt_step;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                    if (timeout_hit)
                    begin
                        phase_next = PH_IDLE;
                        done = 1'b1;
                        err = 1'b1;
                    end
                end
            end
            PH_MEAS:
            begin
                if (fall)
                begin
                    phase_next = PH_IDLE;
                    done = 1'b1;
                    range_held_next = cm_count_reg;
                end
                else
                begin
                    cm_prescale_next = pre_step;
                    cm_count_next = cnt_step;
                    phase_ticks_next = ticks_inc;
                    if (timeout_hit)
                    begin
                        phase_next = PH_IDLE;
                        done = 1'b1;
                        err = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            phase_ticks_reg <= '0;
            cm_prescale_reg <= '0;
            cm_count_reg <= '0;
            echo_before_reg <= 1'b0;
            range_held_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            cm_prescale_reg <= cm_prescale_next;
            cm_count_reg <= cm_count_next;
            echo_before_reg <= smp.echo_level;
            range_held_reg <= range_held_next;
        end
    end

    assign res.trigger_level = (phase_next == PH_TRIG);
    assign res.done_res = done;
    assign res.timed_out = err;
    assign res.range_cm = range_held_next;

`include "ultrasonic_range_controller_macros.svh"

    `URC_ASSERT_NOW(a_done_ends_phase, step_en && done, phase_next == PH_IDLE)
    `URC_ASSERT_NOW(a_count_saturates, 1'b1, cm_count_reg <= urc_pkg::RANGE_MAX)
    `URC_ASSERT_NEXT(a_hold_when_stalled, !step_en,
                     $stable(cm_count_reg) && $stable(phase_ticks_reg))

endmodule
